// ===== rtl/gwmm_pkg.sv =====
// Shared types and default constants of the grayscale window min/max filter.
package gwmm_pkg;

  // Default values for the top-level parameters.
  localparam int unsigned DefMaxRadius = 3;
  localparam int unsigned DefMaxWidth  = 1024;
  localparam int unsigned DefMaxHeight = 1024;

  // Fixed field widths.
  localparam int unsigned PixW    = 8;
  localparam int unsigned CfgIdxW = 2;
  localparam int unsigned CfgDatW = 11;

  // Reset values of the configuration registers.
  localparam int unsigned RadiusRst = 1;
  localparam int unsigned SelMinRst = 0;
  localparam int unsigned WidthRst  = 640;
  localparam int unsigned HeightRst = 480;

  // Identity values of the maximum and minimum reductions.
  localparam logic [PixW-1:0] MaxIdent = 8'd0;
  localparam logic [PixW-1:0] MinIdent = 8'd255;

  // Maximum and minimum of one column, or of a run of columns.
  typedef struct packed {
    logic [PixW-1:0] max_v;
    logic [PixW-1:0] min_v;
  } col_pair_t;

endpackage

// ===== rtl/gwmm_line_store.sv =====
// Line store: one word per column holding the previous rows, with write-to-read forwarding.
module gwmm_line_store #(
  parameter int unsigned Depth = gwmm_pkg::DefMaxWidth,
  parameter int unsigned WordW = 2 * gwmm_pkg::DefMaxRadius * gwmm_pkg::PixW,
  localparam int unsigned AW   = $clog2(Depth)
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             rd_en_i,
  input  logic [AW-1:0]    rd_addr_i,
  input  logic             wr_en_i,
  input  logic [AW-1:0]    wr_addr_i,
  input  logic [WordW-1:0] wr_data_i,
  output logic [WordW-1:0] rd_data_o
);

  logic [WordW-1:0] mem_q [Depth];
  logic [WordW-1:0] rd_q;
  logic [WordW-1:0] fwd_data_q;
  logic             fwd_q;

  always_ff @(posedge clk_i) begin
    if (wr_en_i) begin
      mem_q[wr_addr_i] <= wr_data_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (rd_en_i) begin
      rd_q       <= mem_q[rd_addr_i];
      fwd_data_q <= wr_data_i;
    end
  end

  // A write landing on the address read in the same cycle is forwarded.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      fwd_q <= 1'b0;
    end else if (rd_en_i) begin
      fwd_q <= wr_en_i && (wr_addr_i == rd_addr_i);
    end
  end

  assign rd_data_o = fwd_q ? fwd_data_q : rd_q;

endmodule

// ===== rtl/gwmm_cell.sv =====
// One window column cell: stores a column maximum and minimum and extends the running reduction.
module gwmm_cell (
  input  logic                clk_i,
  input  logic                shift_i,
  input  logic                include_i,
  input  gwmm_pkg::col_pair_t col_i,
  input  gwmm_pkg::col_pair_t acc_i,
  output gwmm_pkg::col_pair_t col_o,
  output gwmm_pkg::col_pair_t acc_o
);

  gwmm_pkg::col_pair_t col_q;

  always_ff @(posedge clk_i) begin
    if (shift_i) begin
      col_q <= col_i;
    end
  end

  assign col_o = col_q;

  always_comb begin
    acc_o = acc_i;
    if (include_i) begin
      if (col_q.max_v > acc_i.max_v) acc_o.max_v = col_q.max_v;
      if (col_q.min_v < acc_i.min_v) acc_o.min_v = col_q.min_v;
    end
  end

endmodule

// ===== rtl/grayscale_window_min_max_filter_unit.sv =====
// Top level of the square-window grayscale maximum / minimum filter.
//
//  Channel  Direction  Payload (low bit first)          Transfer condition
//  s_axis   in         tdata: pixel[7:0]                tvalid & tready
//  m_axis   out        tdata: filtered[7:0], tlast      tvalid & tready
//  cfg      in         index, data (11 bits)            cfg_we_i
//
// The unit takes one pixel per clock cycle and keeps that rate for as long as the
// result side keeps taking transactions; the line store is read once and written
// once per pixel, on separate read and write ports, which sets that figure. A
// result passes stage A, stage B and the output register in turn. Reset clears the
// counters and the pipeline valid flags and returns the configuration to its
// defaults; the line store is left as it is and needs no clearing pass, since no
// result reads a row before it has been written in the current frame. A stalled
// output holds the stages behind it as they fill, and s_axis_tready falls only
// when every stage is full.
module grayscale_window_min_max_filter_unit #(
  parameter int unsigned MaxRadius = gwmm_pkg::DefMaxRadius,
  parameter int unsigned MaxWidth  = gwmm_pkg::DefMaxWidth,
  parameter int unsigned MaxHeight = gwmm_pkg::DefMaxHeight
) (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  // Input stream; tdata: pixel[7:0]
  input  logic                         s_axis_tvalid,
  output logic                         s_axis_tready,
  input  logic [gwmm_pkg::PixW-1:0]    s_axis_tdata,
  // Output stream; tdata: filtered[7:0]; tlast marks the last result of a frame
  output logic                         m_axis_tvalid,
  input  logic                         m_axis_tready,
  output logic [gwmm_pkg::PixW-1:0]    m_axis_tdata,
  output logic                         m_axis_tlast,
  // Configuration write port
  input  logic                         cfg_we_i,
  input  logic [gwmm_pkg::CfgIdxW-1:0] cfg_index_i,
  input  logic [gwmm_pkg::CfgDatW-1:0] cfg_data_i
);

  localparam int unsigned PixW    = gwmm_pkg::PixW;
  localparam int unsigned CfgDatW = gwmm_pkg::CfgDatW;
  localparam int unsigned XW      = $clog2(MaxWidth);
  localparam int unsigned YW      = $clog2(MaxHeight);
  localparam int unsigned RW      = $clog2(MaxRadius + 1);
  localparam int unsigned TW      = RW + 1;
  localparam int unsigned LRows   = 2 * MaxRadius;
  localparam int unsigned NCells  = 2 * MaxRadius + 1;
  localparam int unsigned WordW   = LRows * PixW;

  typedef enum logic [gwmm_pkg::CfgIdxW-1:0] {
    REG_RADIUS     = 2'd0,
    REG_SELECT_MIN = 2'd1,
    REG_WIDTH      = 2'd2,
    REG_HEIGHT     = 2'd3
  } cfg_reg_e;

  // Index of the last column or row for a written dimension, with zero read as one
  // and anything above the limit saturated.
  function automatic logic [XW-1:0] last_col(logic [gwmm_pkg::CfgDatW-1:0] v);
    logic [XW-1:0] res;
    if (v == '0) res = '0;
    else if (int'(v) > int'(MaxWidth)) res = XW'(MaxWidth - 1);
    else res = XW'(v - 1'b1);
    return res;
  endfunction

  function automatic logic [YW-1:0] last_row(logic [gwmm_pkg::CfgDatW-1:0] v);
    logic [YW-1:0] res;
    if (v == '0) res = '0;
    else if (int'(v) > int'(MaxHeight)) res = YW'(MaxHeight - 1);
    else res = YW'(v - 1'b1);
    return res;
  endfunction

  function automatic logic [RW-1:0] sat_radius(logic [1:0] v);
    logic [RW-1:0] res;
    if (int'(v) > int'(MaxRadius)) res = RW'(MaxRadius);
    else res = RW'(v);
    return res;
  endfunction

  // Configuration, held in the form the datapath uses.
  logic [RW-1:0] radius_q;
  logic          sel_min_q;
  logic [XW-1:0] wlast_q;
  logic [YW-1:0] hlast_q;
  logic [TW-1:0] two_r;

  assign two_r = {radius_q, 1'b0};

  // Position of the next pixel in the frame.
  logic [XW-1:0] col_q, col_d;
  logic [YW-1:0] row_q, row_d;
  logic          restart;

  // Pipeline control.
  logic accept, a_move, out_ready, b_ready;
  logic a_q, b_q, out_valid_q;

  // Stage A: accepted pixel waiting for its line-store word.
  logic [PixW-1:0] pix_a_q;
  logic [XW-1:0]   x_a_q;
  logic            res_a_q, last_a_q;

  // Stage B: a result whose window now sits in the cell chain.
  logic b_last_q;

  // Output register.
  logic [PixW-1:0] out_data_q;
  logic            out_last_q;

  logic [WordW-1:0] rd_word, wr_word;
  gwmm_pkg::col_pair_t new_col;
  gwmm_pkg::col_pair_t cell_col [NCells+1];
  gwmm_pkg::col_pair_t cell_acc [NCells+1];
  logic                res_now, last_now;

  assign out_ready     = !out_valid_q || m_axis_tready;
  assign b_ready       = !b_q || out_ready;
  // The chain shifts only when stage B is empty or leaves in the same cycle.
  assign a_move        = a_q && b_ready;
  assign s_axis_tready = !a_q || b_ready;
  assign accept        = s_axis_tvalid && s_axis_tready;

  assign res_now  = (col_q >= XW'(two_r)) && (row_q >= YW'(two_r));
  assign last_now = (col_q == wlast_q) && (row_q == hlast_q);

  // Any geometry write sends the frame back to its first pixel.
  assign restart = cfg_we_i && (cfg_reg_e'(cfg_index_i) != REG_SELECT_MIN);

  always_comb begin
    col_d = col_q;
    row_d = row_q;
    if (restart) begin
      col_d = '0;
      row_d = '0;
    end else if (accept) begin
      if (col_q == wlast_q) begin
        col_d = '0;
        row_d = (row_q == hlast_q) ? '0 : row_q + 1'b1;
      end else begin
        col_d = col_q + 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      radius_q  <= sat_radius(2'(gwmm_pkg::RadiusRst));
      sel_min_q <= 1'(gwmm_pkg::SelMinRst);
      wlast_q   <= last_col(CfgDatW'(gwmm_pkg::WidthRst));
      hlast_q   <= last_row(CfgDatW'(gwmm_pkg::HeightRst));
      col_q     <= '0;
      row_q     <= '0;
    end else begin
      col_q <= col_d;
      row_q <= row_d;
      if (cfg_we_i) begin
        case (cfg_reg_e'(cfg_index_i))
          REG_RADIUS: begin
            radius_q <= sat_radius(cfg_data_i[1:0]);
          end
          REG_SELECT_MIN: begin
            sel_min_q <= cfg_data_i[0];
          end
          REG_WIDTH: begin
            wlast_q <= last_col(cfg_data_i);
          end
          REG_HEIGHT: begin
            hlast_q <= last_row(cfg_data_i);
          end
          default: begin
          end
        endcase
      end
    end
  end

  // Valid flags of the pipeline stages.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      a_q         <= 1'b0;
      b_q         <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      if (accept) a_q <= 1'b1;
      else if (a_move) a_q <= 1'b0;

      if (a_move) b_q <= res_a_q;
      else if (b_q && out_ready) b_q <= 1'b0;

      if (b_q && out_ready) out_valid_q <= 1'b1;
      else if (m_axis_tready) out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      pix_a_q  <= s_axis_tdata;
      x_a_q    <= col_q;
      res_a_q  <= res_now;
      last_a_q <= last_now;
    end
    if (a_move) begin
      b_last_q <= last_a_q;
    end
    if (b_q && out_ready) begin
      out_data_q <= sel_min_q ? cell_acc[NCells].min_v : cell_acc[NCells].max_v;
      out_last_q <= b_last_q;
    end
  end

  // The line-store word of a column holds the rows above it, the most recent in the
  // lowest byte; writing back shifts the new pixel in and drops the oldest row.
  assign wr_word = {rd_word[WordW-PixW-1:0], pix_a_q};

  gwmm_line_store #(
    .Depth (MaxWidth),
    .WordW (WordW)
  ) u_line_store (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .rd_en_i   (accept),
    .rd_addr_i (col_q),
    .wr_en_i   (a_move),
    .wr_addr_i (x_a_q),
    .wr_data_i (wr_word),
    .rd_data_o (rd_word)
  );

  // Column reduction over the rows of the window: the new pixel and the rows above.
  always_comb begin
    logic [PixW-1:0] v;
    new_col.max_v = pix_a_q;
    new_col.min_v = pix_a_q;
    for (int k = 1; k <= LRows; k++) begin
      v = rd_word[k*PixW-1 -: PixW];
      if (TW'(k) <= two_r) begin
        if (v > new_col.max_v) new_col.max_v = v;
        if (v < new_col.min_v) new_col.min_v = v;
      end
    end
  end

  // Chain of column cells; the newest column enters at cell zero.
  assign cell_col[0]       = new_col;
  assign cell_acc[0].max_v = gwmm_pkg::MaxIdent;
  assign cell_acc[0].min_v = gwmm_pkg::MinIdent;

  for (genvar i = 0; i < NCells; i++) begin : g_cell
    gwmm_cell u_cell (
      .clk_i     (clk_i),
      .shift_i   (a_move),
      .include_i (TW'(i) <= two_r),
      .col_i     (cell_col[i]),
      .acc_i     (cell_acc[i]),
      .col_o     (cell_col[i+1]),
      .acc_o     (cell_acc[i+1])
    );
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = out_data_q;
  assign m_axis_tlast  = out_last_q;

  // The cell chain never moves under a result that is still waiting in stage B.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    a_move |-> !(b_q && !out_ready))
    else $error("cell chain shifted under a stalled result");

  // The position counters stay inside the configured frame.
  assert property (@(posedge clk_i) disable iff (!rst_ni) col_q <= wlast_q)
    else $error("column position beyond frame width");

  assert property (@(posedge clk_i) disable iff (!rst_ni) row_q <= hlast_q)
    else $error("row position beyond frame height");

  // A new output transaction comes only from a result held in stage B.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_q) |-> $past(b_q))
    else $error("output became valid without a pending result");

endmodule

// ===== verif/gwmm_tb_pkg.sv =====
// Configuration register indexes shared by the filter testbench files.
`timescale 1ns / 1ps

package gwmm_tb_pkg;

  typedef enum logic [gwmm_pkg::CfgIdxW-1:0] {
    RegRadius = 2'd0,
    RegSelMin = 2'd1,
    RegWidth  = 2'd2,
    RegHeight = 2'd3
  } cfg_reg_e;

endpackage

// ===== verif/gwmm_checker.sv =====
// Checker that predicts and compares the window min/max filter results.
`timescale 1ns / 1ps

module gwmm_checker (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         pix_valid_i,
  input  logic                         pix_ready_i,
  input  logic [gwmm_pkg::PixW-1:0]    pix_data_i,
  input  logic                         res_valid_i,
  input  logic                         res_ready_i,
  input  logic [gwmm_pkg::PixW-1:0]    res_data_i,
  input  logic                         res_last_i,
  input  logic                         cfg_we_i,
  input  logic [gwmm_pkg::CfgIdxW-1:0] cfg_index_i,
  input  logic [gwmm_pkg::CfgDatW-1:0] cfg_data_i,
  output int                           pending_o,
  output int                           fail_count_o
);

  localparam int unsigned PixW         = gwmm_pkg::PixW;
  localparam int unsigned CfgDatW      = gwmm_pkg::CfgDatW;
  localparam int unsigned DefMaxRadius = gwmm_pkg::DefMaxRadius;
  localparam int unsigned DefMaxWidth  = gwmm_pkg::DefMaxWidth;
  localparam int unsigned DefMaxHeight = gwmm_pkg::DefMaxHeight;

  // As many rows as the tallest window, so the row being written never
  // overwrites a row that the current window still needs.
  localparam int LineSlots = 2 * DefMaxRadius + 1;

  typedef struct packed {
    logic [PixW-1:0] value;
    logic            frame_end;
  } filtered_px_t;

  filtered_px_t          awaited_q[$];
  logic [PixW-1:0]       recent_rows [LineSlots][DefMaxWidth];
  logic [1:0]            radius;
  logic                  sel_min;
  logic [CfgDatW-1:0]    width_reg;
  logic [CfgDatW-1:0]    height_reg;
  int                    col;
  int                    row;

  function automatic int clamp_size(logic [CfgDatW-1:0] v, int limit);
    if (v == 0) return 1;
    if (v > limit) return limit;
    return v;
  endfunction

  function automatic void apply_write(gwmm_tb_pkg::cfg_reg_e idx, logic [CfgDatW-1:0] v);
    case (idx)
      gwmm_tb_pkg::RegRadius: begin
        radius = v[1:0];
        col = 0;
        row = 0;
      end
      gwmm_tb_pkg::RegSelMin: sel_min = v[0];
      gwmm_tb_pkg::RegWidth: begin
        width_reg = v;
        col = 0;
        row = 0;
      end
      gwmm_tb_pkg::RegHeight: begin
        height_reg = v;
        col = 0;
        row = 0;
      end
      default: ;
    endcase
  endfunction

  function automatic void take_pixel(logic [PixW-1:0] px);
    int w;
    int h;
    int r;
    int k;
    int d;
    logic [PixW-1:0] acc;
    logic [PixW-1:0] v;
    filtered_px_t e;
    w = clamp_size(width_reg, DefMaxWidth);
    h = clamp_size(height_reg, DefMaxHeight);
    r = (radius > DefMaxRadius) ? DefMaxRadius : radius;
    recent_rows[row % LineSlots][col] = px;
    if (col >= 2 * r && row >= 2 * r) begin
      acc = sel_min ? gwmm_pkg::MinIdent : gwmm_pkg::MaxIdent;
      for (k = 0; k <= 2 * r; k++) begin
        for (d = 0; d <= 2 * r; d++) begin
          v = recent_rows[(row - k) % LineSlots][col - d];
          if (sel_min ? (v < acc) : (v > acc)) acc = v;
        end
      end
      e.value = acc;
      e.frame_end = (col == w - 1) && (row == h - 1);
      awaited_q.push_back(e);
    end
    if (col + 1 >= w) begin
      col = 0;
      row = (row + 1 >= h) ? 0 : row + 1;
    end else begin
      col = col + 1;
    end
  endfunction

  function automatic void note_failure(string msg);
    fail_count_o++;
    if (fail_count_o <= 10) $display("mismatch at %0t: %s", $realtime, msg);
  endfunction

  function automatic void check_result(logic [PixW-1:0] data, logic last);
    filtered_px_t e;
    if (awaited_q.size() == 0) begin
      note_failure($sformatf("unexpected result filtered=%0d last=%0b", data, last));
      return;
    end
    e = awaited_q.pop_front();
    if (data !== e.value)
      note_failure($sformatf("filtered expected %0d actual %0d", e.value, data));
    if (last !== e.frame_end)
      note_failure($sformatf("tlast expected %0b actual %0b", e.frame_end, last));
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      awaited_q.delete();
      fail_count_o = 0;
      radius       = 2'(gwmm_pkg::RadiusRst);
      sel_min      = 1'(gwmm_pkg::SelMinRst);
      width_reg    = CfgDatW'(gwmm_pkg::WidthRst);
      height_reg   = CfgDatW'(gwmm_pkg::HeightRst);
      col          = 0;
      row          = 0;
    end else begin
      // Results are compared before the new pixel is predicted, so a stray
      // result can never be matched against the pixel arriving with it.
      if (res_valid_i && res_ready_i) check_result(res_data_i, res_last_i);
      if (cfg_we_i) apply_write(gwmm_tb_pkg::cfg_reg_e'(cfg_index_i), cfg_data_i);
      if (pix_valid_i && pix_ready_i) take_pixel(pix_data_i);
    end
    pending_o = awaited_q.size();
  end

endmodule

// ===== verif/tb_grayscale_window_min_max_filter_unit.sv =====
// Testbench top of the window min/max filter: stimulus, back-pressure and verdict.
`timescale 1ns / 1ps

module tb_grayscale_window_min_max_filter_unit;

  localparam int unsigned PixW         = gwmm_pkg::PixW;
  localparam int unsigned CfgIdxW      = gwmm_pkg::CfgIdxW;
  localparam int unsigned CfgDatW      = gwmm_pkg::CfgDatW;
  localparam int unsigned DefMaxWidth  = gwmm_pkg::DefMaxWidth;
  localparam int unsigned DefMaxHeight = gwmm_pkg::DefMaxHeight;

  // Roughly how many pixels to send, and how many of the last ones go in
  // without any idling on either side.
  localparam int PixelBudget   = 650;
  localparam int SteadyTail    = 80;
  // Cycles without any transaction or register write before the run is
  // declared hung. The longest legitimate pause is a short drain plus a
  // back-pressure stall, so this is generous.
  localparam int WatchdogLimit = 2000;

  typedef enum int {PixUniform, PixSpiky, PixFlat} pixel_style_e;

  logic                clk_i;
  logic                rst_ni;
  logic                s_axis_tvalid;
  logic                s_axis_tready;
  logic [PixW-1:0]     s_axis_tdata;
  logic                m_axis_tvalid;
  logic                m_axis_tready;
  logic [PixW-1:0]     m_axis_tdata;
  logic                m_axis_tlast;
  logic                cfg_we_i;
  logic [CfgIdxW-1:0]  cfg_index_i;
  logic [CfgDatW-1:0]  cfg_data_i;

  int   pending;
  int   fail_count;
  int   pixels_sent = 0;
  int   dead_cycles = 0;
  int   hold_left   = 0;
  logic src_bursty  = 1'b0;
  logic sink_bursty = 1'b0;
  logic steady_tail = 1'b0;

  grayscale_window_min_max_filter_unit uut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),   // pixel[7:0]
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),   // filtered[7:0]
    .m_axis_tlast  (m_axis_tlast),
    .cfg_we_i      (cfg_we_i),
    .cfg_index_i   (cfg_index_i),
    .cfg_data_i    (cfg_data_i)
  );

  gwmm_checker u_checker (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .pix_valid_i  (s_axis_tvalid),
    .pix_ready_i  (s_axis_tready),
    .pix_data_i   (s_axis_tdata),
    .res_valid_i  (m_axis_tvalid),
    .res_ready_i  (m_axis_tready),
    .res_data_i   (m_axis_tdata),
    .res_last_i   (m_axis_tlast),
    .cfg_we_i     (cfg_we_i),
    .cfg_index_i  (cfg_index_i),
    .cfg_data_i   (cfg_data_i),
    .pending_o    (pending),
    .fail_count_o (fail_count)
  );

  always begin
    clk_i = 1'b1;
    #2;
    clk_i = 1'b0;
    #2;
  end

  // The watchdog counts cycles in which nothing at all is accepted. Register
  // writes count as progress, so the pauses around them do not add up.
  always @(posedge clk_i) begin
    if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready) || cfg_we_i)
      dead_cycles <= 0;
    else
      dead_cycles <= dead_cycles + 1;
  end

  initial begin
    wait (dead_cycles >= WatchdogLimit);
    $display("status: fail");
    $finish;
  end

  // Result-side back-pressure. In bursty stretches tready drops at random and
  // stays low while a drawn hold count runs down; otherwise, and in the closing
  // stretch, it stays high. Only one assignment to tready is made per clock edge.
  initial begin
    m_axis_tready = 1'b0;
    @(posedge rst_ni);
    forever begin
      @(posedge clk_i);
      if (hold_left > 0) begin
        hold_left--;
        m_axis_tready <= 1'b0;
      end else if (sink_bursty && !steady_tail && $urandom_range(0, 7) == 0) begin
        hold_left = $urandom_range(0, 6);
        m_axis_tready <= 1'b0;
      end else begin
        m_axis_tready <= 1'b1;
      end
    end
  end

  function automatic logic [PixW-1:0] pick_pixel(pixel_style_e style);
    case (style)
      PixUniform: return 8'($urandom_range(0, 255));
      // Mid-grey texture with the odd black or white speck, so that the
      // extremes decide the window result now and then.
      PixSpiky: begin
        if ($urandom_range(0, 7) == 0) return $urandom_range(0, 1) ? 8'd255 : 8'd0;
        return 8'($urandom_range(96, 160));
      end
      default: begin
        if ($urandom_range(0, 15) == 0) return 8'($urandom_range(0, 255));
        return 8'd200;
      end
    endcase
  endfunction

  // A register write takes one cycle with the enable high. The leading edge
  // wait keeps back-to-back writes from lowering and raising the enable at
  // the same edge.
  task automatic write_reg(gwmm_tb_pkg::cfg_reg_e idx, logic [CfgDatW-1:0] value);
    @(posedge clk_i);
    cfg_we_i    <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i  <= value;
    @(posedge clk_i);
    cfg_we_i    <= 1'b0;
  endtask

  // Presents one pixel and returns at the edge where the transaction
  // completes. tvalid stays high into the next call unless a gap is drawn.
  task automatic send_pixel(logic [PixW-1:0] px);
    if (src_bursty && !steady_tail && $urandom_range(0, 5) == 0) begin
      s_axis_tvalid <= 1'b0;
      repeat ($urandom_range(1, 7)) @(posedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= px;
    do @(posedge clk_i); while (!s_axis_tready);
    pixels_sent++;
  endtask

  task automatic send_pixels(int count, pixel_style_e style);
    int i;
    for (i = 0; i < count; i++) send_pixel(pick_pixel(style));
  endtask

  // Brings the unit to rest before a register write: every predicted result
  // must have arrived, and then a further wait covers a pixel still in the
  // three-stage pipeline that produces no result.
  task automatic drain();
    s_axis_tvalid <= 1'b0;
    do @(negedge clk_i); while (pending != 0);
    repeat (8) @(posedge clk_i);
  endtask

  function automatic int effective_size(int v);
    if (v == 0) return 1;
    if (v > DefMaxWidth) return DefMaxWidth;
    return v;
  endfunction

  // One random phase: a new setting, then pixels. Most phases send whole
  // frames that fit the window; some cut a frame short, some use the size
  // extremes, some frames are too small for the window, and some only flip
  // the min/max selection and carry on from where the frame stands. No phase
  // sends more than what is left of the pixel budget.
  task automatic random_phase();
    int r;
    int w;
    int h;
    int n;
    int area;
    int kind;
    pixel_style_e style;
    r     = $urandom_range(0, 3);
    w     = $urandom_range(2 * r + 1, 2 * r + 8);
    h     = $urandom_range(2 * r + 1, 2 * r + 6);
    kind  = $urandom_range(0, 9);
    style = pixel_style_e'($urandom_range(0, 2));
    case (kind)
      0: begin
        case ($urandom_range(0, 3))
          0: w = 0;
          1: w = DefMaxWidth;
          2: w = 2047;
          default: w = $urandom_range(DefMaxWidth + 1, 2046);
        endcase
      end
      1: h = $urandom_range(0, 1) ? DefMaxHeight : $urandom_range(DefMaxHeight + 1, 2047);
      2: begin
        w = $urandom_range(0, 2 * r);
        h = $urandom_range(0, 2 * r + 2);
      end
      default: ;
    endcase

    if (kind == 3) begin
      // Selection change only: no restart, the frame continues.
      write_reg(gwmm_tb_pkg::RegSelMin,
                {10'($urandom_range(0, 1023)), 1'($urandom_range(0, 1))});
      n = $urandom_range(10, 40);
    end else begin
      // Upper data bits beyond a narrow register are filled with noise.
      write_reg(gwmm_tb_pkg::RegRadius, {9'($urandom_range(0, 511)), r[1:0]});
      write_reg(gwmm_tb_pkg::RegSelMin,
                {10'($urandom_range(0, 1023)), 1'($urandom_range(0, 1))});
      write_reg(gwmm_tb_pkg::RegWidth, CfgDatW'(w));
      write_reg(gwmm_tb_pkg::RegHeight, CfgDatW'(h));
      area = effective_size(w) * effective_size(h);
      if (area <= 120) begin
        n = area * $urandom_range(1, 3);
        if ($urandom_range(0, 4) == 0) n = n - $urandom_range(1, effective_size(w));
        if (n < 1) n = 1;
      end else begin
        n = $urandom_range(10, 60);
      end
    end
    if (n > PixelBudget - pixels_sent) n = PixelBudget - pixels_sent;
    send_pixels(n, style);
    drain();
  endtask

  initial begin
    rst_ni        = 1'b0;
    s_axis_tvalid = 1'b0;
    s_axis_tdata  = '0;
    cfg_we_i      = 1'b0;
    cfg_index_i   = gwmm_tb_pkg::RegRadius;
    cfg_data_i    = '0;
    repeat (6) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Directed part. A 3x3 frame with the reset radius of one gives exactly
    // one maximum, which carries tlast; white sits off the centre.
    write_reg(gwmm_tb_pkg::RegWidth, 11'd3);
    write_reg(gwmm_tb_pkg::RegHeight, 11'd3);
    send_pixel(8'd10);  send_pixel(8'd0);   send_pixel(8'd255);
    send_pixel(8'd7);   send_pixel(8'd128); send_pixel(8'd1);
    send_pixel(8'd254); send_pixel(8'd3);   send_pixel(8'd9);
    drain();

    // Same geometry in minimum mode; black sits in a corner.
    write_reg(gwmm_tb_pkg::RegSelMin, 11'd1);
    send_pixel(8'd200); send_pixel(8'd255); send_pixel(8'd90);
    send_pixel(8'd17);  send_pixel(8'd254); send_pixel(8'd128);
    send_pixel(8'd64);  send_pixel(8'd33);  send_pixel(8'd0);
    drain();

    // Radius zero: every pixel is its own window. The selection flips in
    // the middle of the frame, which must not restart it.
    write_reg(gwmm_tb_pkg::RegRadius, 11'd0);
    write_reg(gwmm_tb_pkg::RegWidth, 11'd2);
    write_reg(gwmm_tb_pkg::RegHeight, 11'd2);
    send_pixel(8'd255);
    send_pixel(8'd0);
    drain();
    write_reg(gwmm_tb_pkg::RegSelMin, 11'd0);
    send_pixel(8'd0);
    send_pixel(8'd128);
    drain();

    // Zero sizes act as a single-pixel frame, far smaller than the widest
    // window: the pixels are taken and nothing comes out.
    write_reg(gwmm_tb_pkg::RegRadius, 11'd3);
    write_reg(gwmm_tb_pkg::RegWidth, 11'd0);
    write_reg(gwmm_tb_pkg::RegHeight, 11'd0);
    send_pixel(8'd77);
    send_pixel(8'd78);
    drain();

    // Random part; both sides run bursty or steady per phase, and the
    // closing stretch runs with no idling at all.
    while (pixels_sent < PixelBudget) begin
      if (pixels_sent >= PixelBudget - SteadyTail) steady_tail = 1'b1;
      src_bursty  = $urandom_range(0, 1);
      sink_bursty = $urandom_range(0, 1);
      random_phase();
    end

    // drain() has already waited for the last result and the pipeline depth.
    if (fail_count == 0 && pending == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

endmodule

// ===== sim.f =====
rtl/gwmm_pkg.sv
rtl/gwmm_line_store.sv
rtl/gwmm_cell.sv
rtl/grayscale_window_min_max_filter_unit.sv
verif/gwmm_tb_pkg.sv
verif/gwmm_checker.sv
verif/tb_grayscale_window_min_max_filter_unit.sv
